>>> design/b2bcd6_pkg.sv
// Package: widths, constants and types for the six-digit saturating binary-to-BCD converter.
`default_nettype none
package b2bcd6_pkg;

	localparam int unsigned IN_W        = 32;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned DIGITS      = 6;
	localparam int unsigned VAL_W       = 20;
	localparam int unsigned RECIP_SHIFT = 23;
	localparam int unsigned PROD_W      = 2 * VAL_W;

	// Largest number six tubes can show.
	localparam logic [IN_W-1:0]  DISP_MAX_IN = 32'd999999;
	localparam logic [VAL_W-1:0] DISP_MAX    = 20'd999999;

	// ceil(2^23 / 10): exact quotient by ten for any 20-bit operand.
	localparam logic [VAL_W-1:0] RECIP_TEN   = 20'd838861;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [VAL_W-1:0]   value_t;
	typedef digit_t [DIGITS-1:0] digit_vec_t;

endpackage
`default_nettype wire

>>> design/b2bcd6_in_if.sv
// Interface: input channel carrying one binary word.
`default_nettype none
interface b2bcd6_in_if;
	logic                            valid;
	logic                            ready;
	logic [b2bcd6_pkg::IN_W-1:0]     binary_value;

	modport source (output valid, output binary_value, input ready);
	modport sink   (input valid, input binary_value, output ready);
endinterface
`default_nettype wire

>>> design/b2bcd6_out_if.sv
// Interface: output channel carrying six decimal digits and the saturation flag.
`default_nettype none
interface b2bcd6_out_if;
	logic                   valid;
	logic                   ready;
	b2bcd6_pkg::digit_t     digit_units;
	b2bcd6_pkg::digit_t     digit_tens;
	b2bcd6_pkg::digit_t     digit_hundreds;
	b2bcd6_pkg::digit_t     digit_thousands;
	b2bcd6_pkg::digit_t     digit_ten_thousands;
	b2bcd6_pkg::digit_t     digit_hundred_thousands;
	logic                   clamped;

	modport source (output valid, output digit_units, output digit_tens,
		output digit_hundreds, output digit_thousands, output digit_ten_thousands,
		output digit_hundred_thousands, output clamped, input ready);
	modport sink (input valid, input digit_units, input digit_tens,
		input digit_hundreds, input digit_thousands, input digit_ten_thousands,
		input digit_hundred_thousands, input clamped, output ready);
endinterface
`default_nettype wire

>>> design/binary_to_bcd_six_digit_saturating_top.sv
// Top level: pipelined saturating conversion of a 32-bit binary word to six BCD digits.
//
// Usage:
//   bin  - sink channel; each word carries a 32-bit unsigned binary_value.
//   bcd  - source channel; each word carries six decimal digits (units first
//          up to hundred-thousands) and a clamped flag.
//   A word moves on a rising clk edge where valid and ready are both high.
//   Values above 999999 come out as 999999 with clamped set; 999999 itself
//   comes out with clamped clear.
// Pipeline: six register stages. Stage one saturates the value to 20 bits;
// each of the next five divides by ten with a constant reciprocal multiply
// (one 20x20 product per stage) and peels off one digit. The quotient left
// in the last stage is the hundred-thousands digit.
// Path: an accepted word passes stage one, then the five divide stages, to bcd.
// Throughput: one word per cycle while bcd.ready is high; bin.ready is high whenever some stage
// can advance, so bubbles are squeezed out.
// Stall: while bcd.ready is low the last stage holds its word; earlier
// stages keep filling until the pipeline is full, then bin.ready drops.
// Nothing is dropped or repeated.
// Reset: arst_n clears all stage valid bits at once; digit payload is not
// reset. The block keeps no other state.
`default_nettype none
module binary_to_bcd_six_digit_saturating_top (
	input  wire              clk,
	input  wire              arst_n,
	b2bcd6_in_if.sink        bin,
	b2bcd6_out_if.source     bcd
);

	localparam int unsigned NSTAGE = b2bcd6_pkg::DIGITS;
	localparam int unsigned LAST   = NSTAGE - 1;

	// Stage registers, indexed by stage (index 0 is stage one).
	logic                   valid_s  [NSTAGE];
	b2bcd6_pkg::value_t     val_s    [NSTAGE];
	b2bcd6_pkg::digit_vec_t dig_s    [NSTAGE];
	logic                   clamp_s  [NSTAGE];

	// Load enable per stage: take a new word when empty or when the word
	// held can move on.
	logic                   load     [NSTAGE];

	always_comb begin
		load[LAST] = !valid_s[LAST] || bcd.ready;
		for (int j = int'(LAST) - 1; j >= 0; j--) begin
			load[j] = !valid_s[j] || load[j+1];
		end
	end

	assign bin.ready = load[0];

	// Stage one: saturate to the display maximum.
	logic                   over_max;
	b2bcd6_pkg::value_t     sat_val;

	assign over_max = bin.binary_value > b2bcd6_pkg::DISP_MAX_IN;
	assign sat_val  = over_max ? b2bcd6_pkg::DISP_MAX
		: bin.binary_value[b2bcd6_pkg::VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (load[0]) begin
			valid_s[0] <= bin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			val_s[0]   <= sat_val;
			clamp_s[0] <= over_max;
			dig_s[0]   <= '0;
		end
	end

	// Divide stages: quotient by reciprocal multiply, digit is the remainder.
	genvar g;
	generate
		for (g = 1; g < NSTAGE; g++) begin : g_div
			logic [b2bcd6_pkg::PROD_W-1:0] prod;
			b2bcd6_pkg::value_t            quot;
			b2bcd6_pkg::value_t            rem;
			b2bcd6_pkg::digit_vec_t        dig_next;

			always_comb begin
				prod = b2bcd6_pkg::PROD_W'(val_s[g-1])
					* b2bcd6_pkg::PROD_W'(b2bcd6_pkg::RECIP_TEN);
				quot = b2bcd6_pkg::VAL_W'(prod >> b2bcd6_pkg::RECIP_SHIFT);
				rem  = val_s[g-1] - (quot << 3) - (quot << 1);
				dig_next        = dig_s[g-1];
				dig_next[g-1]   = rem[b2bcd6_pkg::DIGIT_W-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g] <= 1'b0;
				end else if (load[g]) begin
					valid_s[g] <= valid_s[g-1];
				end
			end

			always_ff @(posedge clk) begin
				if (load[g]) begin
					val_s[g]   <= quot;
					clamp_s[g] <= clamp_s[g-1];
					dig_s[g]   <= dig_next;
				end
			end
		end
	endgenerate

	// Output: the last stage is the output register; its quotient is the top digit.
	assign bcd.valid                   = valid_s[LAST];
	assign bcd.digit_units             = dig_s[LAST][0];
	assign bcd.digit_tens              = dig_s[LAST][1];
	assign bcd.digit_hundreds          = dig_s[LAST][2];
	assign bcd.digit_thousands         = dig_s[LAST][3];
	assign bcd.digit_ten_thousands     = dig_s[LAST][4];
	assign bcd.digit_hundred_thousands = val_s[LAST][b2bcd6_pkg::DIGIT_W-1:0];
	assign bcd.clamped                 = clamp_s[LAST];

	// A saturated word shows all nines.
	a_clamp_nines: assert property (@(posedge clk) disable iff (!arst_n)
		(bcd.valid && bcd.clamped) |->
		(bcd.digit_units == 4'd9 && bcd.digit_tens == 4'd9
		&& bcd.digit_hundreds == 4'd9 && bcd.digit_thousands == 4'd9
		&& bcd.digit_ten_thousands == 4'd9 && bcd.digit_hundred_thousands == 4'd9))
		else $error("clamped word does not read 999999");

	// Every delivered digit is decimal.
	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		bcd.valid |->
		(bcd.digit_units <= 4'd9 && bcd.digit_tens <= 4'd9
		&& bcd.digit_hundreds <= 4'd9 && bcd.digit_thousands <= 4'd9
		&& bcd.digit_ten_thousands <= 4'd9 && bcd.digit_hundred_thousands <= 4'd9))
		else $error("non-decimal digit on output");

	// An accepted word occupies stage one on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(bin.valid && bin.ready) |=> valid_s[0])
		else $error("accepted word lost at stage one");

	// An empty output stage never blocks the input.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s[LAST] |-> bin.ready)
		else $error("input stalled with free pipeline");

	// The quotient left for the top digit is a single decimal digit.
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[LAST] |-> (val_s[LAST] <= b2bcd6_pkg::VAL_W'(9)))
		else $error("top quotient exceeds nine");

endmodule
`default_nettype wire

>>> test/binary_to_bcd_six_digit_saturating_top_test.sv
// Testbench: six-digit saturating binary-to-BCD converter, checked word by word against a predictor.
`timescale 1ns / 100ps
module binary_to_bcd_six_digit_saturating_top_test;

	localparam int unsigned CLK_HALF    = 4;
	localparam int unsigned RESET_LEN   = 11;
	localparam int unsigned HOLD_CYCLES = 48;
	localparam int unsigned TAIL_CYCLES = 12;
	// Bound for the whole run, with a wide margin over the slowest correct run.
	localparam int unsigned CYCLE_LIMIT = 200000;

	// One converted word as the display sees it.
	typedef struct packed {
		b2bcd6_pkg::digit_t units;
		b2bcd6_pkg::digit_t tens;
		b2bcd6_pkg::digit_t hundreds;
		b2bcd6_pkg::digit_t thousands;
		b2bcd6_pkg::digit_t ten_thousands;
		b2bcd6_pkg::digit_t hundred_thousands;
		logic               clamped;
	} bcd_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	b2bcd6_in_if  bin_ch ();
	b2bcd6_out_if bcd_ch ();

	binary_to_bcd_six_digit_saturating_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bin    (bin_ch),
		.bcd    (bcd_ch)
	);

	// Values waiting to be offered, and predicted words waiting to come out.
	logic [b2bcd6_pkg::IN_W-1:0] pending_values[$];
	bcd_word_t                   expected_words[$];
	bcd_word_t                   head_word;

	// Pacing knobs, changed only from the sequencer at the falling edge.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_request   = 1'b0;
	int unsigned hold_left;

	int unsigned cycle_count   = 0;
	int unsigned words_sent    = 0;
	int unsigned words_checked = 0;
	int unsigned words_clamped = 0;
	int unsigned input_stalls  = 0;
	int unsigned mismatches    = 0;

	always #(CLK_HALF) clk = ~clk;

	// Saturate to the display maximum, then peel off decimal digits, units first.
	function automatic bcd_word_t to_decimal(input logic [b2bcd6_pkg::IN_W-1:0] raw);
		logic [b2bcd6_pkg::IN_W-1:0] rest;
		bcd_word_t                   w;
		w.clamped           = (raw > b2bcd6_pkg::DISP_MAX_IN);
		rest                = w.clamped ? b2bcd6_pkg::DISP_MAX_IN : raw;
		w.units             = b2bcd6_pkg::digit_t'(rest % 10);
		rest                = rest / 10;
		w.tens              = b2bcd6_pkg::digit_t'(rest % 10);
		rest                = rest / 10;
		w.hundreds          = b2bcd6_pkg::digit_t'(rest % 10);
		rest                = rest / 10;
		w.thousands         = b2bcd6_pkg::digit_t'(rest % 10);
		rest                = rest / 10;
		w.ten_thousands     = b2bcd6_pkg::digit_t'(rest % 10);
		rest                = rest / 10;
		w.hundred_thousands = b2bcd6_pkg::digit_t'(rest % 10);
		return w;
	endfunction

	// Queue random values, weighted toward the displayable range and its edges.
	task automatic queue_random_values(input int unsigned count);
		logic [b2bcd6_pkg::IN_W-1:0] v;
		logic [b2bcd6_pkg::IN_W-1:0] power;
		repeat (count) begin
			case ($urandom_range(9))
				0, 1, 2, 3: v = $urandom_range(999999);
				4:          v = $urandom_range(99);
				5:          v = b2bcd6_pkg::DISP_MAX_IN - 3 + $urandom_range(6);
				6:          v = $urandom();
				7:          v = $urandom() >> $urandom_range(31);
				default: begin
					// Land on or next to a power of ten.
					power = 1;
					repeat ($urandom_range(6)) power = power * 10;
					v = power - 1 + $urandom_range(2);
				end
			endcase
			pending_values.push_back(v);
		end
	endtask

	// Hold the sequencer until every queued value is sent and every predicted word has come out.
	task automatic wait_drained();
		while (pending_values.size() != 0 || bin_ch.valid || expected_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_pacing(input int unsigned idle_pct, input int unsigned stall_pct);
		@(negedge clk);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic check_digit(input string name, input logic [3:0] want, input logic [3:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Driver: offer the next pending value; record a prediction for each accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_ch.valid        <= 1'b0;
			bin_ch.binary_value <= '0;
		end else begin
			if (bin_ch.valid && bin_ch.ready) begin
				expected_words.push_back(to_decimal(bin_ch.binary_value));
				words_sent++;
			end
			if (bin_ch.valid && !bin_ch.ready)
				input_stalls++;
			// Advance only when the current word has gone or nothing is offered.
			if (!bin_ch.valid || bin_ch.ready) begin
				if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					bin_ch.valid        <= 1'b1;
					bin_ch.binary_value <= pending_values.pop_front();
				end else begin
					bin_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here so the sender keeps pushing into a full pipeline.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_request) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: stall at random, and all the time during a hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_ch.ready <= 1'b0;
		end else begin
			bcd_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: compare every word taken from the output with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && bcd_ch.valid && bcd_ch.ready) begin
			if (expected_words.size() == 0) begin
				$error("output word with no conversion pending");
				mismatches++;
			end else begin
				head_word = expected_words.pop_front();
				check_digit("digit_units", head_word.units, bcd_ch.digit_units);
				check_digit("digit_tens", head_word.tens, bcd_ch.digit_tens);
				check_digit("digit_hundreds", head_word.hundreds, bcd_ch.digit_hundreds);
				check_digit("digit_thousands", head_word.thousands, bcd_ch.digit_thousands);
				check_digit("digit_ten_thousands", head_word.ten_thousands,
					bcd_ch.digit_ten_thousands);
				check_digit("digit_hundred_thousands", head_word.hundred_thousands,
					bcd_ch.digit_hundred_thousands);
				check_digit("clamped", 4'(head_word.clamped), 4'(bcd_ch.clamped));
				words_checked++;
				if (head_word.clamped)
					words_clamped++;
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, expected_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Sequencer: reset, then four pacing phases with a drain between each.
	initial begin
		bin_ch.valid        = 1'b0;
		bin_ch.binary_value = '0;
		bcd_ch.ready        = 1'b0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one, no idling: the edges first.
		pending_values.push_back(32'd0);
		pending_values.push_back(32'd1);
		pending_values.push_back(32'd9);
		pending_values.push_back(32'd10);
		pending_values.push_back(32'd19);
		pending_values.push_back(32'd99);
		pending_values.push_back(32'd100);
		pending_values.push_back(32'd99999);
		pending_values.push_back(32'd100000);
		pending_values.push_back(32'd123456);
		pending_values.push_back(32'd500000);
		pending_values.push_back(32'd987654);
		pending_values.push_back(32'd999998);
		pending_values.push_back(b2bcd6_pkg::DISP_MAX_IN);     // exactly at the maximum: no clamp
		pending_values.push_back(b2bcd6_pkg::DISP_MAX_IN + 1); // just above: clamp
		pending_values.push_back(32'd1048575);
		pending_values.push_back(32'h7FFF_FFFF);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h5555_5555);
		pending_values.push_back(32'hAAAA_AAAA);
		pending_values.push_back(32'hFFFF_FFFF);        // largest input: clamp
		wait_drained();

		// Fill the pipeline behind a long hold-off while the sender keeps offering.
		queue_random_values(60);
		@(negedge clk);
		hold_request = 1'b1;
		@(negedge clk);
		hold_request = 1'b0;
		wait_drained();
		queue_random_values(170);
		wait_drained();

		set_pacing(54, 0);
		queue_random_values(230);
		wait_drained();

		set_pacing(0, 54);
		queue_random_values(230);
		wait_drained();

		set_pacing(17, 17);
		queue_random_values(230);
		wait_drained();

		// Let any stray word surface before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("%0d predicted words never arrived", expected_words.size());
			mismatches++;
		end

		$display("Checked %0d of %0d words (%0d saturated) over four pacing phases,",
			words_checked, words_sent, words_clamped);
		$display("input held back on %0d cycles, %0d mismatches.", input_stalls, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
